// ===== src/srpc_pkg.sv =====
// ----------------------------------------------------------------------------
// srpc_pkg: shared types and constants of the seed radius point clusterer
// Request and result payloads, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package srpc_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned LABEL_W    = 7;
  localparam int unsigned LIMIT_W    = 34;
  localparam int unsigned DIST_W     = 2 * COORD_W + 2;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned REG_IDX_W  = 1;

  // Register index of the squared radius limit.
  localparam logic [REG_IDX_W-1:0] REG_RADIUS = 1'b0;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } point_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [LABEL_W-1:0]        cluster_label;
    logic                      last_center;
  } center_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_SEED_RD,
    ST_SCAN,
    ST_SQUARE,
    ST_TEST,
    ST_DIV,
    ST_EMIT
  } srpc_state_e;

  typedef struct packed {
    logic store_wr;
    logic seed_clear;
    logic seed_adv;
    logic seed_take;
    logic seed_load;
    logic scan_adv;
    logic scan_rd;
    logic square;
    logic test;
    logic div_start;
    logic emit;
    logic set_clear;
  } srpc_cmd_t;

  typedef struct packed {
    logic seed_labeled;
    logic scan_end;
    logic scan_labeled;
    logic div_done;
    logic set_done;
  } srpc_status_t;

endpackage

// ===== src/srpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// srpc_ctrl: sequencing state machine of the point clusterer
// Walks load, seed search, member scan, centroid division and emission.
// ----------------------------------------------------------------------------
module srpc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  last_i,
  input  srpc_pkg::srpc_status_t status_i,
  output srpc_pkg::srpc_cmd_t    cmd_o,
  output logic                  busy_o
);

  srpc_pkg::srpc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srpc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      srpc_pkg::ST_IDLE: begin
        if (start_i && last_i) state_d = srpc_pkg::ST_SEED;
      end
      srpc_pkg::ST_SEED: begin
        if (!status_i.seed_labeled) state_d = srpc_pkg::ST_SEED_RD;
      end
      srpc_pkg::ST_SEED_RD: state_d = srpc_pkg::ST_SCAN;
      srpc_pkg::ST_SCAN: begin
        if (status_i.scan_end) begin
          state_d = srpc_pkg::ST_DIV;
        end else if (!status_i.scan_labeled) begin
          state_d = srpc_pkg::ST_SQUARE;
        end
      end
      srpc_pkg::ST_SQUARE: state_d = srpc_pkg::ST_TEST;
      srpc_pkg::ST_TEST:   state_d = srpc_pkg::ST_SCAN;
      srpc_pkg::ST_DIV: begin
        if (status_i.div_done) state_d = srpc_pkg::ST_EMIT;
      end
      srpc_pkg::ST_EMIT: begin
        state_d = status_i.set_done ? srpc_pkg::ST_IDLE : srpc_pkg::ST_SEED;
      end
      default: state_d = srpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      srpc_pkg::ST_IDLE: begin
        busy_o           = 1'b0;
        cmd_o.store_wr   = start_i;
        cmd_o.seed_clear = start_i && last_i;
      end
      srpc_pkg::ST_SEED: begin
        cmd_o.seed_adv  = status_i.seed_labeled;
        cmd_o.seed_take = !status_i.seed_labeled;
      end
      srpc_pkg::ST_SEED_RD: cmd_o.seed_load = 1'b1;
      srpc_pkg::ST_SCAN: begin
        cmd_o.div_start = status_i.scan_end;
        cmd_o.scan_adv  = !status_i.scan_end && status_i.scan_labeled;
        cmd_o.scan_rd   = !status_i.scan_end && !status_i.scan_labeled;
      end
      srpc_pkg::ST_SQUARE: cmd_o.square = 1'b1;
      srpc_pkg::ST_TEST:   cmd_o.test = 1'b1;
      srpc_pkg::ST_DIV:    cmd_o = '0;
      srpc_pkg::ST_EMIT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.set_clear = status_i.set_done;
      end
      default: busy_o = 1'b1;
    endcase
  end

endmodule

// ===== src/srpc_div.sv =====
// ----------------------------------------------------------------------------
// srpc_div: serial signed divider for one centroid coordinate
// Restoring division of the coordinate sum by the member count, one quotient
// bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module srpc_div #(
  parameter int unsigned SUM_W = 22,
  parameter int unsigned CNT_W = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [SUM_W-1:0]            sum_i,
  input  logic [CNT_W-1:0]                   count_i,
  output logic                               done_o,
  output logic signed [srpc_pkg::COORD_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic              neg_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  den_q;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    trial;
  logic              fits;
  logic [SUM_W-1:0]  signed_quo;

  assign mag   = sum_i[SUM_W-1] ? (~sum_i + 1'b1) : sum_i;
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == STEP_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(SUM_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= sum_i[SUM_W-1];
      quo_q <= mag;
      rem_q <= '0;
      den_q <= count_i;
    end else if (busy_q) begin
      rem_q <= fits ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

  assign signed_quo = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quot_o     = signed_quo[srpc_pkg::COORD_W-1:0];
  assign done_o     = done_q;

endmodule

// ===== src/srpc_dpath.sv =====
// ----------------------------------------------------------------------------
// srpc_dpath: datapath of the point clusterer
// Point memory, label flags, seed and scan pointers, the squared distance
// pipeline, per-cluster sums and the result register.
// ----------------------------------------------------------------------------
module srpc_dpath #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  srpc_pkg::srpc_cmd_t                cmd_i,
  input  srpc_pkg::point_req_t               point_i,
  input  logic [srpc_pkg::LIMIT_W-1:0]       limit_i,
  output srpc_pkg::srpc_status_t             status_o,
  output logic                              res_valid_o,
  output srpc_pkg::center_res_t              res_o
);

  localparam int unsigned CW    = srpc_pkg::COORD_W;
  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned SUM_W = CW + $clog2(MAX_POINTS);
  localparam int unsigned DW    = srpc_pkg::DIST_W;

  logic [2*CW-1:0]         mem_q [MAX_POINTS];
  logic [2*CW-1:0]         rd_q;
  logic [MAX_POINTS-1:0]   labeled_q;
  logic [CNT_W-1:0]        loaded_q;
  logic [CNT_W-1:0]        lab_total_q;
  logic [CNT_W-1:0]        i_q;
  logic [CNT_W-1:0]        j_q;
  logic [srpc_pkg::LABEL_W-1:0] label_q;
  logic signed [CW-1:0]    seed_x_q, seed_y_q;
  logic signed [DW-1:0]    sqx_q, sqy_q;
  logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
  logic [CNT_W-1:0]        count_q;
  logic                    res_valid_q;
  srpc_pkg::center_res_t    res_q;

  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic signed [CW-1:0]    rd_x, rd_y;
  logic signed [CW:0]      dx, dy;
  logic [DW:0]             sq_sum;
  logic                    hit;
  logic                    div_done_x, div_done_y;
  logic signed [CW-1:0]    quot_x, quot_y;

  assign rd_x    = rd_q[2*CW-1:CW];
  assign rd_y    = rd_q[CW-1:0];
  assign rd_en   = cmd_i.seed_take || cmd_i.scan_rd;
  assign rd_addr = cmd_i.seed_take ? i_q[IDX_W-1:0] : j_q[IDX_W-1:0];
  assign dx      = {rd_x[CW-1], rd_x} - {seed_x_q[CW-1], seed_x_q};
  assign dy      = {rd_y[CW-1], rd_y} - {seed_y_q[CW-1], seed_y_q};
  assign sq_sum  = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign hit     = sq_sum < {{(DW + 1 - srpc_pkg::LIMIT_W){1'b0}}, limit_i};

  // Point memory: one write port for loading, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr && (loaded_q < CNT_W'(MAX_POINTS))) begin
      mem_q[loaded_q[IDX_W-1:0]] <= {point_i.point_x, point_i.point_y};
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      labeled_q   <= '0;
      loaded_q    <= '0;
      lab_total_q <= '0;
      label_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
      if (cmd_i.store_wr && (loaded_q < CNT_W'(MAX_POINTS))) begin
        loaded_q <= loaded_q + 1'b1;
      end
      if (cmd_i.seed_clear) i_q <= '0;
      if (cmd_i.seed_adv)   i_q <= i_q + 1'b1;
      if (cmd_i.seed_take) begin
        labeled_q[i_q[IDX_W-1:0]] <= 1'b1;
        lab_total_q <= lab_total_q + 1'b1;
        label_q     <= label_q + 1'b1;
      end
      if (cmd_i.seed_load) j_q <= i_q + 1'b1;
      if (cmd_i.scan_adv)  j_q <= j_q + 1'b1;
      if (cmd_i.test) begin
        j_q <= j_q + 1'b1;
        if (hit) begin
          labeled_q[j_q[IDX_W-1:0]] <= 1'b1;
          lab_total_q <= lab_total_q + 1'b1;
        end
      end
      if (cmd_i.set_clear) begin
        labeled_q   <= '0;
        loaded_q    <= '0;
        lab_total_q <= '0;
        label_q     <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_load) begin
      seed_x_q <= rd_x;
      seed_y_q <= rd_y;
      sum_x_q  <= {{(SUM_W - CW){rd_x[CW-1]}}, rd_x};
      sum_y_q  <= {{(SUM_W - CW){rd_y[CW-1]}}, rd_y};
      count_q  <= CNT_W'(1);
    end
    if (cmd_i.square) begin
      sqx_q <= dx * dx;
      sqy_q <= dy * dy;
    end
    if (cmd_i.test && hit) begin
      sum_x_q <= sum_x_q + {{(SUM_W - CW){rd_x[CW-1]}}, rd_x};
      sum_y_q <= sum_y_q + {{(SUM_W - CW){rd_y[CW-1]}}, rd_y};
      count_q <= count_q + 1'b1;
    end
    if (cmd_i.emit) begin
      res_q.center_x      <= quot_x;
      res_q.center_y      <= quot_y;
      res_q.cluster_label <= label_q;
      res_q.last_center   <= (lab_total_q == loaded_q);
    end
  end

  srpc_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .sum_i   (sum_x_q),
    .count_i (count_q),
    .done_o  (div_done_x),
    .quot_o  (quot_x)
  );

  srpc_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .sum_i   (sum_y_q),
    .count_i (count_q),
    .done_o  (div_done_y),
    .quot_o  (quot_y)
  );

  assign status_o.seed_labeled = labeled_q[i_q[IDX_W-1:0]];
  assign status_o.scan_end     = (j_q == loaded_q);
  assign status_o.scan_labeled = labeled_q[j_q[IDX_W-1:0]];
  assign status_o.div_done     = div_done_x && div_done_y;
  assign status_o.set_done     = (lab_total_q == loaded_q);

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/seed_radius_point_clusterer.sv =====
// ----------------------------------------------------------------------------
// seed_radius_point_clusterer: leader clustering of a 2-D point set
// Loads signed points, groups them around seeds by squared radius and emits
// one centroid per cluster in label order.
// ----------------------------------------------------------------------------
// Usage: each request on point_i is taken at a clock edge with start high and
// busy low. A request without last_point only stores the point (the block
// stays ready). A request with last_point stores it and starts clustering;
// points beyond MAX_POINTS are dropped but their last mark counts.
// Clustering runs one pass per cluster: the seed search skips labeled points
// and fetches the next unlabeled one as the seed, then each later unlabeled
// point takes a memory read, the two squaring multipliers, and an add and
// compare, while a point already labeled is skipped; then the scan closes,
// the serial dividers run and the centroid is emitted. SUM_W, the sum and
// divider width, is 16 plus log2(MAX_POINTS), 22 at the default size. The
// point memory read port and the dividers set the pace of a pass. Each
// centroid shows on result_o for exactly one cycle with result_valid_o high;
// the receiver cannot stall, so nothing waits. busy falls in the cycle of the
// last centroid. Reset clears the control state and label flags at once; the
// point memory needs no clearing pass. radius_sq_limit sits at APB address 0.
// ----------------------------------------------------------------------------
module seed_radius_point_clusterer #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  srpc_pkg::point_req_t                  point_i,
  output logic                                 result_valid_o,
  output srpc_pkg::center_res_t                 result_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [srpc_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [srpc_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [srpc_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  logic [srpc_pkg::LIMIT_W-1:0]   limit_q;
  logic [srpc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_wr;
  srpc_pkg::srpc_cmd_t             cmd;
  srpc_pkg::srpc_status_t          status;

  // Registers sit on 8-byte boundaries, so the index is the address over 8.
  assign reg_idx = paddr[srpc_pkg::APB_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_wr && (reg_idx == srpc_pkg::REG_RADIUS)) begin
      limit_q <= pwdata[srpc_pkg::LIMIT_W-1:0];
    end
  end

  // Reads return the limit zero-extended; unmapped addresses read as zero.
  assign prdata = (reg_idx == srpc_pkg::REG_RADIUS) ?
                  {{(srpc_pkg::APB_DATA_W - srpc_pkg::LIMIT_W){1'b0}}, limit_q} : '0;

  // The controller sequences the passes; the datapath holds the point and cluster storage.
  srpc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .last_i   (point_i.last_point),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  srpc_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .point_i     (point_i),
    .limit_i     (limit_q),
    .status_o    (status),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

`ifndef NO_ASSERTIONS
  // Centroids are separated by at least a divider run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back centroid strobes");

  // The final centroid of a set hands the block back to the requester.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_center) |-> !busy)
    else $error("still busy after the final centroid");

  // More centroids are still to come while the set is not finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last_center) |-> busy)
    else $error("idle before the final centroid");

  // Labels start at one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.cluster_label != '0))
    else $error("centroid with label zero");
`endif

endmodule
